// ===== rtl/lcd_mode_sequencer_core_assert.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef LCD_MODE_SEQUENCER_CORE_ASSERT_SVH
`define LCD_MODE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define LMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lms assertion failed");

// next-cycle implication
`define LMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lms assertion failed");

`endif

// ===== rtl/lms_pkg.sv =====
// types, constants and helpers of the lcd mode sequencer
// no dependencies
package lms_pkg;

   localparam int unsigned HBLANK_LEN   = 204;
   localparam int unsigned SCAN_LEN     = 80;
   localparam int unsigned DRAW_LEN     = 172;
   localparam int unsigned LINE_LEN     = 456;
   localparam int unsigned VBLANK_LEN   = 4560;
   localparam int unsigned LAST_VISIBLE = 143;
   localparam int unsigned Y_OFFSET     = 16;
   localparam logic [7:0]  MODE_MASK    = 8'hFC;
   localparam int unsigned MAX_ITER     = 8;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_STORE   = 1'b1;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_SCAN   = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LCD_ENABLE     = 3'd0,
      CSR_SPRITE_ENABLE  = 3'd1,
      CSR_TALL_SPRITES   = 3'd2,
      CSR_COMPARE_LINE   = 3'd3,
      CSR_IRQ_ON_COMPARE = 3'd4,
      CSR_IRQ_ON_SCAN    = 3'd5,
      CSR_IRQ_ON_VBLANK  = 3'd6,
      CSR_IRQ_ON_HBLANK  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {F_IDLE, F_RUN, F_STORE, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_READ, B_EVAL, B_FLUSH} back_state_type;

   typedef struct packed {
      logic       command;
      logic [7:0] cycles;
      logic [5:0] sprite_slot;
      logic [7:0] sprite_y;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       line_match;
      logic       vblank_irq;
      logic       stat_irq;
      logic       oam_locked;
      logic       vram_locked;
      logic       draw_request;
      logic       sprite_valid;
      logic [5:0] sprite_index;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       lcd_enable;
      logic       sprite_enable;
      logic       tall_sprites;
      logic [7:0] compare_line;
      logic       irq_on_compare;
      logic       irq_on_scan;
      logic       irq_on_vblank;
      logic       irq_on_hblank;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       line_match;
      logic       vblank_irq;
      logic       stat_irq;
      logic       draw_request;
      logic       sel;
      logic [7:0] sel_line;
   } job_type;

   // number of whole lines in a v-blank cycle count (below 4560)
   function automatic logic [3:0] line_quot(input logic [12:0] v);
      logic [3:0] q;
      q = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (v >= 13'(k * LINE_LEN)) q = 4'(k);
      end
      return q;
   endfunction

endpackage

// ===== rtl/lms_ram.sv =====
// generic single-write, registered-read ram
// no dependencies
module lms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/lms_job_fifo.sv =====
// two-entry queue of classified items between front and back
// depends on lms_pkg
module lms_job_fifo
   import lms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);
   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end
endmodule

// ===== rtl/lms_front.sv =====
// front: accepts items, runs the mode and line timing, writes sprite y bytes
// depends on lms_pkg
module lms_front
   import lms_pkg::*;
#(
   parameter int SPRITE_ENTRIES = 40
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    job_push,
   input  logic    job_full,
   input  logic    job_empty,
   output job_type job,
   input  logic    back_busy,
   output logic    ram_we,
   output logic [(SPRITE_ENTRIES > 1 ? $clog2(SPRITE_ENTRIES) : 1)-1:0] ram_waddr,
   output logic [7:0] ram_wdata
);
   localparam int AW = SPRITE_ENTRIES > 1 ? $clog2(SPRITE_ENTRIES) : 1;

   front_state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [12:0] cycle_count_ff, cycle_count_in;
   logic [7:0]  line_ff, line_in;
   logic        match_ff, match_in;
   logic [3:0]  cond_ff, cond_in;
   logic [13:0] cc_ff, cc_in;
   logic [12:0] from_ff, from_in;
   logic [3:0]  iter_ff, iter_in;
   logic        pv_ff, pv_in, ps_ff, ps_in, pd_ff, pd_in, sel_ff, sel_in;
   logic [7:0]  sel_line_ff, sel_line_in;
   logic [5:0]  slot_ff, slot_in;
   logic [7:0]  y_ff, y_in;

   logic [7:0]  step_l;
   logic        step_m;
   logic [3:0]  step_c, mode_c;
   logic [12:0] top;
   logic        accept;

   assign accept   = req_push && !req_full;
   assign req_full = state_ff != F_IDLE;

   // one line step on the current line and flags
   always_comb begin
      step_l = line_ff + 8'd1;
      step_m = step_l == cfg.compare_line;
      step_c = cond_ff;
      if (!step_m) step_c[3] = 1'b0;
      else if (cfg.irq_on_compare) step_c[3] = 1'b1;
      top = (cc_ff < 14'(VBLANK_LEN)) ? cc_ff[12:0] : 13'(VBLANK_LEN - 1);
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      cycle_count_in = cycle_count_ff;
      line_in        = line_ff;
      match_in       = match_ff;
      cond_in        = cond_ff;
      cc_in          = cc_ff;
      from_in        = from_ff;
      iter_in        = iter_ff;
      pv_in          = pv_ff;
      ps_in          = ps_ff;
      pd_in          = pd_ff;
      sel_in         = sel_ff;
      sel_line_in    = sel_line_ff;
      slot_in        = slot_ff;
      y_in           = y_ff;
      mode_c         = cond_ff;
      job_push       = 1'b0;
      ram_we         = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               pv_in   = 1'b0;
               ps_in   = 1'b0;
               pd_in   = 1'b0;
               sel_in  = 1'b0;
               slot_in = req_data.sprite_slot;
               y_in    = req_data.sprite_y;
               cc_in   = 14'(cycle_count_ff) + 14'(req_data.cycles);
               from_in = cycle_count_ff;
               iter_in = 4'd0;
               if (req_data.command == CMD_STORE) state_in = F_STORE;
               else if (cfg.lcd_enable) state_in = F_RUN;
               else state_in = F_PUSH;
            end
         end
         F_RUN: begin
            if (iter_ff == 4'(MAX_ITER)) begin
               cycle_count_in = cc_ff[12:0];
               state_in       = F_PUSH;
            end else begin
               case (mode_ff)
                  MODE_HBLANK: begin
                     if (cc_ff >= 14'(HBLANK_LEN)) begin
                        cc_in    = cc_ff - 14'(HBLANK_LEN);
                        line_in  = step_l;
                        match_in = step_m;
                        mode_c   = step_c;
                        if (step_l > 8'(LAST_VISIBLE)) begin
                           mode_in   = MODE_VBLANK;
                           mode_c[1] = cfg.irq_on_vblank;
                           pv_in     = 1'b1;
                           from_in   = 13'd0;
                        end else begin
                           mode_in   = MODE_SCAN;
                           mode_c[2] = cfg.irq_on_scan;
                        end
                        cond_in = mode_c;
                        ps_in   = ps_ff || ((|step_c) && !(|cond_ff))
                                        || ((|mode_c) && !(|step_c));
                        iter_in = iter_ff + 4'd1;
                     end else begin
                        cycle_count_in = cc_ff[12:0];
                        state_in       = F_PUSH;
                     end
                  end
                  MODE_VBLANK: begin
                     if (line_quot(from_ff) < line_quot(top)) begin
                        // one v-blank line a cycle, not an iteration
                        line_in  = step_l;
                        match_in = step_m;
                        cond_in  = step_c;
                        ps_in    = ps_ff || ((|step_c) && !(|cond_ff));
                        from_in  = from_ff + 13'(LINE_LEN);
                     end else if (cc_ff >= 14'(VBLANK_LEN)) begin
                        cc_in     = cc_ff - 14'(VBLANK_LEN);
                        line_in   = 8'd0;
                        mode_in   = MODE_SCAN;
                        mode_c[2] = cfg.irq_on_scan;
                        cond_in   = mode_c;
                        ps_in     = ps_ff || ((|mode_c) && !(|cond_ff));
                        iter_in   = iter_ff + 4'd1;
                     end else begin
                        cycle_count_in = cc_ff[12:0];
                        state_in       = F_PUSH;
                     end
                  end
                  MODE_SCAN: begin
                     if (cc_ff >= 14'(SCAN_LEN)) begin
                        cc_in       = cc_ff - 14'(SCAN_LEN);
                        sel_in      = cfg.sprite_enable;
                        sel_line_in = line_ff;
                        mode_in     = MODE_DRAW;
                        iter_in     = iter_ff + 4'd1;
                     end else begin
                        cycle_count_in = cc_ff[12:0];
                        state_in       = F_PUSH;
                     end
                  end
                  default: begin
                     if (cc_ff >= 14'(DRAW_LEN)) begin
                        cc_in     = cc_ff - 14'(DRAW_LEN);
                        mode_in   = MODE_HBLANK;
                        mode_c[0] = cfg.irq_on_hblank;
                        cond_in   = mode_c;
                        ps_in     = ps_ff || ((|mode_c) && !(|cond_ff));
                        pd_in     = 1'b1;
                        iter_in   = iter_ff + 4'd1;
                     end else begin
                        cycle_count_in = cc_ff[12:0];
                        state_in       = F_PUSH;
                     end
                  end
               endcase
            end
         end
         F_STORE: begin
            // wait until no sprite scan can see the old byte
            if (job_empty && !back_busy) begin
               ram_we   = {1'b0, slot_ff} < 7'(SPRITE_ENTRIES);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            job_push = 1'b1;
            if (!job_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign ram_waddr = slot_ff[AW-1:0];
   assign ram_wdata = y_ff;

   always_comb begin
      job.mode         = cfg.lcd_enable ? mode_ff : (mode_ff & MODE_MASK[1:0]);
      job.line         = line_ff;
      job.line_match   = match_ff;
      job.vblank_irq   = pv_ff;
      job.stat_irq     = ps_ff;
      job.draw_request = pd_ff;
      job.sel          = sel_ff;
      job.sel_line     = sel_line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         mode_ff        <= MODE_HBLANK;
         cycle_count_ff <= 13'd0;
         line_ff        <= 8'd0;
         match_ff       <= 1'b0;
         cond_ff        <= 4'd0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         cycle_count_ff <= cycle_count_in;
         line_ff        <= line_in;
         match_ff       <= match_in;
         cond_ff        <= cond_in;
      end
   end

   always_ff @(posedge clock) begin
      cc_ff       <= cc_in;
      from_ff     <= from_in;
      iter_ff     <= iter_in;
      pv_ff       <= pv_in;
      ps_ff       <= ps_in;
      pd_ff       <= pd_in;
      sel_ff      <= sel_in;
      sel_line_ff <= sel_line_in;
      slot_ff     <= slot_in;
      y_ff        <= y_in;
   end
endmodule

// ===== rtl/lms_back.sv =====
// back: sprite scan over the y store and result delivery
// depends on lms_pkg
module lms_back
   import lms_pkg::*;
#(
   parameter int SPRITE_ENTRIES = 40,
   parameter int MAX_PER_LINE   = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    tall_sprites,
   input  logic    job_empty,
   output logic    job_pop,
   input  job_type job,
   output logic    busy,
   output logic    ram_re,
   output logic [(SPRITE_ENTRIES > 1 ? $clog2(SPRITE_ENTRIES) : 1)-1:0] ram_raddr,
   input  logic [7:0] ram_rdata,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   localparam int AW = SPRITE_ENTRIES > 1 ? $clog2(SPRITE_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_PER_LINE + 1);

   back_state_type state_ff, state_in;
   job_type    job_ff, job_in;
   logic [5:0] idx_ff, idx_in, pend_ff, pend_in;
   logic       pend_v_ff, pend_v_in, first_ff, first_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic       out_v_ff, out_v_in;
   rsp_type    out_ff, out_in;

   logic [8:0] y_top, diff;
   logic       hit, out_free, done;

   assign out_free = !out_v_ff || rsp_pop;
   assign busy     = state_ff != B_IDLE;
   assign ram_raddr = idx_ff[AW-1:0];
   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      y_top = 9'(job_ff.sel_line) + 9'(Y_OFFSET);
      diff  = y_top - 9'(ram_rdata);
      hit   = (y_top >= 9'(ram_rdata)) && (diff < (tall_sprites ? 9'd16 : 9'd8));
   end

   function automatic rsp_type make_rsp(input job_type j, input logic first,
                                         input logic valid, input logic [5:0] index,
                                         input logic last);
      rsp_type r;
      r.mode         = j.mode;
      r.line         = j.line;
      r.line_match   = j.line_match;
      r.vblank_irq   = first && j.vblank_irq;
      r.stat_irq     = first && j.stat_irq;
      r.oam_locked   = j.mode == MODE_SCAN || j.mode == MODE_DRAW;
      r.vram_locked  = j.mode == MODE_DRAW;
      r.draw_request = first && j.draw_request;
      r.sprite_valid = valid;
      r.sprite_index = valid ? index : 6'd0;
      r.last         = last;
      return r;
   endfunction

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      out_v_in  = out_v_ff && !rsp_pop;
      out_in    = out_ff;
      job_pop   = 1'b0;
      ram_re    = 1'b0;
      done      = hit && (cnt_ff + CW'(1) == CW'(MAX_PER_LINE))
                  || idx_ff == 6'(SPRITE_ENTRIES - 1);
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop   = 1'b1;
               job_in    = job;
               idx_in    = 6'd0;
               cnt_in    = '0;
               pend_v_in = 1'b0;
               first_in  = 1'b1;
               state_in  = job.sel ? B_READ : B_FLUSH;
            end
         end
         B_READ: begin
            ram_re   = 1'b1;
            state_in = B_EVAL;
         end
         B_EVAL: begin
            // an earlier hit goes out once the next one shows it was not the last
            if (!(hit && pend_v_ff && !out_free)) begin
               if (hit && pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_in   = make_rsp(job_ff, first_ff, 1'b1, pend_ff, 1'b0);
                  first_in = 1'b0;
               end
               if (hit) begin
                  pend_in   = idx_ff;
                  pend_v_in = 1'b1;
                  cnt_in    = cnt_ff + CW'(1);
               end
               if (done) state_in = B_FLUSH;
               else begin
                  idx_in   = idx_ff + 6'd1;
                  state_in = B_READ;
               end
            end
         end
         B_FLUSH: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_in   = make_rsp(job_ff, first_ff, pend_v_ff, pend_ff, 1'b1);
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      idx_ff    <= idx_in;
      pend_ff   <= pend_in;
      pend_v_ff <= pend_v_in;
      first_ff  <= first_in;
      cnt_ff    <= cnt_in;
      out_ff    <= out_in;
   end
endmodule

// ===== rtl/lcd_mode_sequencer_core.sv =====
// top level of the lcd mode sequencer: config registers, front, queue, back, y store
// depends on lms_pkg, lms_ram, lms_job_fifo, lms_front, lms_back
//
//  channel   ports                                 moves
//  request   req_push / req_full / req_data        advance or sprite store item
//  response  rsp_empty / rsp_pop / rsp_data        status, one per selected sprite, at least one per item
//  csr       csr_write_enable / csr_index / data   register write, no wait
//
// an advance steps through the front one mode step or one v-blank line at a time;
// a store waits until no scan is running, then writes its y byte and pushes its item
// sprite selection reads the y store at most once per entry, each through B_READ and
// B_EVAL, limited by the single ram read port
// synchronous reset; the y store is not cleared
// a stalled rsp holds the back, then the two-entry queue fills and req_full stays high
module lcd_mode_sequencer_core
   import lms_pkg::*;
#(
   parameter int SPRITE_ENTRIES = 40,
   parameter int MAX_PER_LINE   = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);
   localparam int AW = SPRITE_ENTRIES > 1 ? $clog2(SPRITE_ENTRIES) : 1;

   cfg_type cfg_ff, cfg_in;
   job_type job_wr, job_rd;
   logic    job_push, job_full, job_pop, job_empty, back_busy;
   logic    ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LCD_ENABLE:     cfg_in.lcd_enable     = csr_write_data[0];
            CSR_SPRITE_ENABLE:  cfg_in.sprite_enable  = csr_write_data[0];
            CSR_TALL_SPRITES:   cfg_in.tall_sprites   = csr_write_data[0];
            CSR_COMPARE_LINE:   cfg_in.compare_line   = csr_write_data;
            CSR_IRQ_ON_COMPARE: cfg_in.irq_on_compare = csr_write_data[0];
            CSR_IRQ_ON_SCAN:    cfg_in.irq_on_scan    = csr_write_data[0];
            CSR_IRQ_ON_VBLANK:  cfg_in.irq_on_vblank  = csr_write_data[0];
            CSR_IRQ_ON_HBLANK:  cfg_in.irq_on_hblank  = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   lms_front #(.SPRITE_ENTRIES(SPRITE_ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_push  (job_push),
      .job_full  (job_full),
      .job_empty (job_empty),
      .job       (job_wr),
      .back_busy (back_busy),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   lms_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   lms_ram #(.WIDTH(8), .DEPTH(SPRITE_ENTRIES)) u_ystore (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lms_back #(.SPRITE_ENTRIES(SPRITE_ENTRIES), .MAX_PER_LINE(MAX_PER_LINE)) u_back (
      .clock        (clock),
      .reset        (reset),
      .tall_sprites (cfg_ff.tall_sprites),
      .job_empty    (job_empty),
      .job_pop      (job_pop),
      .job          (job_rd),
      .busy         (back_busy),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );
endmodule

// ===== rtl/lms_checker.sv =====
// port-level checks of the lcd mode sequencer, bound to the top level
// depends on lms_pkg and lcd_mode_sequencer_core_assert.svh
`include "lcd_mode_sequencer_core_assert.svh"
module lms_checker
   import lms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);
   // a waiting result holds
   `LMS_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_data))
   // a status-only result is always the only one of its item
   `LMS_ASSERT_IMPLY(a_status_last, clock, reset, !rsp_empty && !rsp_data.sprite_valid, rsp_data.last)
   // lock outputs follow the shown mode
   `LMS_ASSERT_IMPLY(a_locks, clock, reset, !rsp_empty, (rsp_data.oam_locked == (rsp_data.mode == MODE_SCAN || rsp_data.mode == MODE_DRAW)) && (rsp_data.vram_locked == (rsp_data.mode == MODE_DRAW)))
   // an accepted item keeps the front busy for at least the next cycle
   `LMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_push && !req_full, req_full)
endmodule

bind lcd_mode_sequencer_core lms_checker u_lms_checker (.*);
